### rtl/nhe_pkg.sv
// Shared types and constants for the n-gram hash embedding id block.
// No dependencies; imported by every module of the block.
package nhe_pkg;

    localparam int HEADS = 8;
    localparam int HEAD_W = 3;

    // Item kinds
    localparam logic [1:0] OP_TOKEN = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_LOAD  = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_MULT_CURRENT  = 3'd0;
    localparam logic [2:0] REG_MULT_PREVIOUS = 3'd1;
    localparam logic [2:0] REG_MULT_OLDER    = 3'd2;
    localparam logic [2:0] REG_EOS_TOKEN     = 3'd3;
    localparam logic [2:0] REG_HEADS_IN_USE  = 3'd4;
    localparam logic [2:0] REG_BIGRAM_HEADS  = 3'd5;

    // Queue entry between front and back; on a load, mix_bi carries the
    // modulus and mix_tri the row offset in their low 31 bits.
    typedef struct packed {
        logic              is_load;
        logic [63:0]       mix_bi;
        logic [63:0]       mix_tri;
        logic [HEAD_W-1:0] sel;
    } nhe_entry_t;

    // Head settings seen by the back end
    typedef struct packed {
        logic [3:0] heads_in_use;
        logic [3:0] bigram_heads;
    } nhe_head_cfg_t;

endpackage

### rtl/ngram_hash_embedding_ids.sv
// Top level of the n-gram hash embedding id block: configuration registers
// and the front end, queue and back end. Uses nhe_pkg and all nhe_ modules.
//
// A token item gives one row id per head in use, in head order, with last
// set on the final one; start and load items give no result. The front end
// forms each token's mixes from six 31x32 partial products on one multiplier,
// then folds the last one and queues the item; a load item is queued as is.
// The back end works out each head's remainder one dividend bit a cycle;
// that bit-serial remainder unit sets the rate.
// A two-entry queue lets the front end take the next items meanwhile.
module ngram_hash_embedding_ids
    import nhe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_addr,
    input  logic [63:0]        cfg_data,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         opcode,
    input  logic [30:0]        token,
    input  logic [30:0]        older_token,
    input  logic [2:0]         head_select,
    input  logic [30:0]        modulus,
    input  logic [30:0]        row_offset,
    output logic               empty,
    input  logic               pop,
    output logic [2:0]         head_index,
    output logic signed [31:0] head_id,
    output logic               last
);

    logic [63:0]   mult_current_reg;
    logic [63:0]   mult_previous_reg;
    logic [63:0]   mult_older_reg;
    logic [30:0]   eos_token_reg;
    nhe_head_cfg_t head_cfg_reg;

    logic          q_wr, q_full, q_rd, q_empty;
    nhe_entry_t    q_wdata, q_rdata;

    // Hold the configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mult_current_reg          <= '0;
            mult_previous_reg         <= '0;
            mult_older_reg            <= '0;
            eos_token_reg             <= '0;
            head_cfg_reg.heads_in_use <= 4'd8;
            head_cfg_reg.bigram_heads <= 4'd4;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_MULT_CURRENT:  mult_current_reg <= cfg_data;
                REG_MULT_PREVIOUS: mult_previous_reg <= cfg_data;
                REG_MULT_OLDER:    mult_older_reg <= cfg_data;
                REG_EOS_TOKEN:     eos_token_reg <= cfg_data[30:0];
                REG_HEADS_IN_USE:  head_cfg_reg.heads_in_use <= cfg_data[3:0];
                REG_BIGRAM_HEADS:  head_cfg_reg.bigram_heads <= cfg_data[3:0];
                default:           eos_token_reg <= eos_token_reg;
            endcase
        end
    end

    nhe_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .opcode        (opcode),
        .token         (token),
        .older_token   (older_token),
        .head_select   (head_select),
        .modulus       (modulus),
        .row_offset    (row_offset),
        .mult_current  (mult_current_reg),
        .mult_previous (mult_previous_reg),
        .mult_older    (mult_older_reg),
        .eos_token     (eos_token_reg),
        .q_wr          (q_wr),
        .q_data        (q_wdata),
        .q_full        (q_full)
    );

    nhe_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_data (q_wdata),
        .full    (q_full),
        .rd      (q_rd),
        .rd_data (q_rdata),
        .empty   (q_empty)
    );

    nhe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_data     (q_rdata),
        .q_empty    (q_empty),
        .q_rd       (q_rd),
        .head_cfg   (head_cfg_reg),
        .empty      (empty),
        .pop        (pop),
        .head_index (head_index),
        .head_id    (head_id),
        .last       (last)
    );

endmodule

### rtl/nhe_fifo.sv
// Two-entry queue between the front and back ends.
// Depends on nhe_pkg for the entry type.
module nhe_fifo
    import nhe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr,
    input  nhe_entry_t wr_data,
    output logic       full,
    input  logic       rd,
    output nhe_entry_t rd_data,
    output logic       empty
);

    nhe_entry_t mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign rd_data = mem[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr && !full)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (rd && !empty)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if ((wr && !full) && !(rd && !empty))
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!(wr && !full) && (rd && !empty))
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the item
    always_ff @(posedge clk)
    begin
        if (wr && !full)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

endmodule

### rtl/nhe_front.sv
// Front end: accepts items, keeps the token history and forms the 64-bit
// bigram and trigram mixes with one shared 31x32 multiplier. Uses nhe_pkg.
module nhe_front
    import nhe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  opcode,
    input  logic [30:0] token,
    input  logic [30:0] older_token,
    input  logic [2:0]  head_select,
    input  logic [30:0] modulus,
    input  logic [30:0] row_offset,
    input  logic [63:0] mult_current,
    input  logic [63:0] mult_previous,
    input  logic [63:0] mult_older,
    input  logic [30:0] eos_token,
    output logic        q_wr,
    output nhe_entry_t  q_data,
    input  logic        q_full
);

    typedef enum logic [1:0] {F_IDLE, F_MUL, F_PUSH} state_t;

    state_t      state_reg;
    logic [30:0] prev_reg, two_back_reg;
    logic [30:0] tok_reg, y1_reg, y2_reg;
    logic [2:0]  step_reg;
    logic [62:0] prod_reg;
    logic [62:0] lo_reg;
    nhe_entry_t  entry_reg;

    logic [30:0] op_a;
    logic [31:0] op_b;
    logic [2:0]  k;
    logic [63:0] part;

    assign full   = (state_reg != F_IDLE);
    assign q_wr   = (state_reg == F_PUSH);
    assign q_data = entry_reg;
    assign k      = step_reg - 3'd1;
    assign part   = {1'b0, lo_reg} + {prod_reg[31:0], 32'h0};

    // Pick the multiplier operands for this step: low then high half
    always_comb
    begin
        case (step_reg[2:1])
            2'd0: begin op_a = tok_reg; op_b = step_reg[0] ? mult_current[63:32]
                                                           : mult_current[31:0]; end
            2'd1: begin op_a = y1_reg;  op_b = step_reg[0] ? mult_previous[63:32]
                                                           : mult_previous[31:0]; end
            2'd2: begin op_a = y2_reg;  op_b = step_reg[0] ? mult_older[63:32]
                                                           : mult_older[31:0]; end
            default: begin op_a = '0; op_b = '0; end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= F_IDLE;
            prev_reg     <= '0;
            two_back_reg <= '0;
            step_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (push)
                    begin
                        case (opcode)
                            OP_TOKEN:
                            begin
                                // Hold the three tokens, shift the history
                                tok_reg      <= token;
                                y1_reg       <= prev_reg;
                                y2_reg       <= (prev_reg == eos_token) ? eos_token
                                                                        : two_back_reg;
                                two_back_reg <= prev_reg;
                                prev_reg     <= token;
                                step_reg     <= '0;
                                state_reg    <= F_MUL;
                            end
                            OP_START:
                            begin
                                prev_reg     <= token;
                                two_back_reg <= older_token;
                            end
                            OP_LOAD:
                            begin
                                entry_reg.is_load <= 1'b1;
                                entry_reg.mix_bi  <= {33'h0, modulus};
                                entry_reg.mix_tri <= {33'h0, row_offset};
                                entry_reg.sel     <= head_select;
                                state_reg         <= F_PUSH;
                            end
                            default:
                            begin
                                state_reg <= F_IDLE;
                            end
                        endcase
                    end
                end
                F_MUL:
                begin
                    prod_reg <= op_a * op_b;
                    step_reg <= step_reg + 3'd1;
                    // Fold the previous step's partial product into the mixes
                    if (step_reg != 3'd0)
                    begin
                        case (k)
                            3'd1: entry_reg.mix_bi  <= part;
                            3'd3: entry_reg.mix_bi  <= entry_reg.mix_bi ^ part;
                            3'd5: entry_reg.mix_tri <= entry_reg.mix_bi ^ part;
                            default: lo_reg <= prod_reg;
                        endcase
                    end
                    if (step_reg == 3'd6)
                    begin
                        entry_reg.is_load <= 1'b0;
                        entry_reg.sel     <= '0;
                        state_reg         <= F_PUSH;
                    end
                end
                F_PUSH:
                begin
                    if (!q_full)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == F_MUL |-> step_reg <= 3'd6)
        else $error("multiply step out of range");

endmodule

### rtl/nhe_back.sv
// Back end: holds the head tables and works out one row id per head with a
// bit-serial signed remainder unit and an output register. Uses nhe_pkg.
module nhe_back
    import nhe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  nhe_entry_t         q_data,
    input  logic               q_empty,
    output logic               q_rd,
    input  nhe_head_cfg_t      head_cfg,
    output logic               empty,
    input  logic               pop,
    output logic [HEAD_W-1:0]  head_index,
    output logic signed [31:0] head_id,
    output logic               last
);

    typedef enum logic [1:0] {B_IDLE, B_DIV, B_FIN} state_t;

    state_t            state_reg;
    logic [30:0]       mod_tab [HEADS];
    logic [30:0]       off_tab [HEADS];
    nhe_entry_t        job_reg;
    logic [3:0]        n_reg;
    logic [HEAD_W-1:0] head_reg;
    logic [5:0]        cnt_reg;
    logic [63:0]       dvd_reg;
    logic [31:0]       rem_reg;
    logic              neg_reg;
    logic              out_valid_reg;
    logic [HEAD_W-1:0] out_head_reg;
    logic [31:0]       out_id_reg;
    logic              out_last_reg;

    logic [3:0]        n_use;
    logic [63:0]       mix_sel;
    logic [63:0]       mag;
    logic [31:0]       m_ext;
    logic [31:0]       trial;
    logic [31:0]       rem_step;
    logic [31:0]       r_fix;
    logic              is_last;
    logic              out_free;
    logic [HEAD_W-1:0] head_first;

    assign empty      = !out_valid_reg;
    assign head_index = out_head_reg;
    assign head_id    = out_id_reg;
    assign last       = out_last_reg;
    assign q_rd       = (state_reg == B_IDLE) && !q_empty;
    assign out_free   = !out_valid_reg || pop;
    assign head_first = '0;

    // Clamp the head count to the number of heads built
    assign n_use = (head_cfg.heads_in_use > 4'(HEADS)) ? 4'(HEADS)
                                                      : head_cfg.heads_in_use;

    // Pick the bigram or trigram mix for a head and take its magnitude
    function automatic logic [63:0] pick_mix(input nhe_entry_t e, input logic [HEAD_W-1:0] h,
                                             input logic [3:0] hpn);
        pick_mix = ({1'b0, h} >= hpn) ? e.mix_tri : e.mix_bi;
    endfunction

    assign mix_sel = pick_mix(q_rd ? q_data : job_reg,
                              q_rd ? head_first : head_reg + HEAD_W'(1),
                              head_cfg.bigram_heads);
    assign mag     = mix_sel[63] ? (~mix_sel + 64'd1) : mix_sel;

    // One restoring remainder step
    assign m_ext    = {1'b0, mod_tab[head_reg]};
    assign trial    = {rem_reg[30:0], dvd_reg[63]};
    assign rem_step = (trial >= m_ext) ? trial - m_ext : trial;

    // Fold the remainder back for a negative mix
    assign r_fix   = (m_ext == 32'h0) ? 32'h0
                   : (neg_reg && rem_reg != 32'h0) ? m_ext - rem_reg : rem_reg;
    assign is_last = ({1'b0, head_reg} + 4'd1 == n_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            head_reg      <= '0;
            cnt_reg       <= '0;
            n_reg         <= '0;
        end
        else
        begin
            // Drop the taken item unless a new one replaces it
            if (pop && out_valid_reg && state_reg != B_FIN)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE:
                begin
                    if (!q_empty && !q_data.is_load && n_use != 4'd0)
                    begin
                        job_reg   <= q_data;
                        n_reg     <= n_use;
                        head_reg  <= '0;
                        dvd_reg   <= mag;
                        neg_reg   <= mix_sel[63];
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= B_DIV;
                    end
                end
                B_DIV:
                begin
                    // Shift in one dividend bit a cycle
                    rem_reg <= rem_step;
                    dvd_reg <= {dvd_reg[62:0], 1'b0};
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63)
                    begin
                        state_reg <= B_FIN;
                    end
                end
                B_FIN:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_head_reg  <= head_reg;
                        out_id_reg    <= r_fix + {1'b0, off_tab[head_reg]};
                        out_last_reg  <= is_last;
                        if (is_last)
                        begin
                            state_reg <= B_IDLE;
                        end
                        else
                        begin
                            head_reg  <= head_reg + HEAD_W'(1);
                            dvd_reg   <= mag;
                            neg_reg   <= mix_sel[63];
                            rem_reg   <= '0;
                            cnt_reg   <= '0;
                            state_reg <= B_DIV;
                        end
                    end
                    else if (pop && out_valid_reg)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    // Write a head's table entry on a load item
    always_ff @(posedge clk)
    begin
        if (q_rd && q_data.is_load)
        begin
            mod_tab[q_data.sel] <= q_data.mix_bi[30:0];
            off_tab[q_data.sel] <= q_data.mix_tri[30:0];
        end
    end

    a_head_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != B_IDLE |-> {1'b0, head_reg} < n_reg)
        else $error("head beyond heads in use");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !pop |=> out_valid_reg && $stable(out_id_reg))
        else $error("waiting result overwritten");

    a_fin_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_DIV && cnt_reg == 6'd63 |=> state_reg == B_FIN)
        else $error("remainder unit missed its finish");

endmodule
